/* hdl/jbr_pkg.sv */
// Shared types and constants for the JSON bracket repair stream.
package jbr_pkg;

    // Input commands
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Register index (word address) of the configuration register
    localparam logic REG_BUFFER_SIZE = 1'b0;

    localparam logic [16:0] BUFFER_SIZE_RESET = 17'd4096;

    // Characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ','
    localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Byte classes found by the front end
    typedef enum logic [2:0] {
        CLS_OTHER         = 3'd0,
        CLS_OPEN_BRACE    = 3'd1,
        CLS_OPEN_BRACKET  = 3'd2,
        CLS_CLOSE_BRACE   = 3'd3,
        CLS_CLOSE_BRACKET = 3'd4,
        CLS_BLANK         = 3'd5,
        CLS_COMMA         = 3'd6
    } cls_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic       cmd;
        cls_t       cls;
        logic [7:0] data_byte;
    } item_t;

    // Stream settings derived from the configuration register
    typedef struct packed {
        logic [15:0] limit;         // bytes that may be written
        logic        size_nonzero;
    } cfg_t;

    // Result item; write_enable sits in the lowest bit once packed
    typedef struct packed {
        logic [15:0] final_length;
        logic        success;
        logic [15:0] comma_position;
        logic        fix_comma;
        logic [7:0]  write_byte;
        logic [15:0] write_position;
        logic        write_enable;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        case (b)
            CH_LBRACE: c = CLS_OPEN_BRACE;
            CH_LBRACK: c = CLS_OPEN_BRACKET;
            CH_RBRACE: c = CLS_CLOSE_BRACE;
            CH_RBRACK: c = CLS_CLOSE_BRACKET;
            CH_COMMA:  c = CLS_COMMA;
            CH_SPACE,
            CH_TAB,
            CH_LF,
            CH_CR:     c = CLS_BLANK;
            default:   c = CLS_OTHER;
        endcase
        return c;
    endfunction

endpackage

/* hdl/jbr_front.sv */
// Front end: takes input transfers, classifies the byte, holds one item.
module jbr_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    output logic          item_valid,
    input  logic          item_ready,
    output jbr_pkg::item_t item
);
    import jbr_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (item_ready) begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            valid_next          = 1'b1;
            item_next.cmd       = s_tuser;
            item_next.cls       = classify(s_tdata);
            item_next.data_byte = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

/* hdl/jbr_queue.sv */
// Short FIFO of classified items between front and back end.
module jbr_queue #(
    parameter int DEPTH = 4   // power of two, at least 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  jbr_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output jbr_pkg::item_t rd_item
);
    import jbr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    item_t         slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = wr_ptr_reg + AW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (!do_wr && do_rd) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            slots_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* hdl/jbr_back.sv */
// Back end: bracket stack, buffer position tracking, closer emission, output register.
module jbr_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  jbr_pkg::cfg_t     cfg,
    input  logic              item_valid,
    output logic              item_ready,
    input  jbr_pkg::item_t    item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output jbr_pkg::result_t  result,
    output logic              m_tlast
);
    import jbr_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_CLOSE = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic                   started_reg, started_next;
    logic [15:0]            written_reg, written_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [STACK_DEPTH-1:0] kinds_reg, kinds_next;   // top of stack in bit 0
    logic [15:0]            vis_pos_reg, vis_pos_next;
    logic                   vis_comma_reg, vis_comma_next;
    logic                   fix_pend_reg, fix_pend_next;
    logic [15:0]            cpos_reg, cpos_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   out_last_reg, out_last_next;

    logic                   load_ok;
    logic                   is_open, is_close, close_kind;
    logic                   room;
    logic [15:0]            written_inc;
    logic [STACK_DEPTH:0]   push_vec, pop_vec;
    logic                   ok;
    logic                   fix_now;

    assign load_ok     = !out_valid_reg || m_tready;
    assign item_ready  = (state_reg == ST_RUN) && load_ok;
    assign m_tvalid    = out_valid_reg;
    assign result      = out_reg;
    assign m_tlast     = out_last_reg;

    assign is_open     = (item.cls == CLS_OPEN_BRACE) || (item.cls == CLS_OPEN_BRACKET);
    assign is_close    = (item.cls == CLS_CLOSE_BRACE) || (item.cls == CLS_CLOSE_BRACKET);
    assign close_kind  = (item.cls == CLS_CLOSE_BRACKET);
    assign room        = (written_reg < cfg.limit);
    assign written_inc = written_reg + 16'd1;
    assign push_vec    = {kinds_reg, (item.cls == CLS_OPEN_BRACKET)};
    assign pop_vec     = {1'b0, kinds_reg};
    assign ok          = started_reg && cfg.size_nonzero;
    assign fix_now     = (depth_reg != '0) && vis_comma_reg;

    always_comb begin
        state_next     = state_reg;
        started_next   = started_reg;
        written_next   = written_reg;
        depth_next     = depth_reg;
        kinds_next     = kinds_reg;
        vis_pos_next   = vis_pos_reg;
        vis_comma_next = vis_comma_reg;
        fix_pend_next  = fix_pend_reg;
        cpos_next      = cpos_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RUN: begin
                if (item_valid && load_ok) begin
                    if (item.cmd == CMD_DATA) begin
                        if ((started_reg || is_open) && room) begin
                            started_next = 1'b1;
                            if (is_open) begin
                                if (depth_reg != DW'(STACK_DEPTH)) begin
                                    kinds_next = push_vec[STACK_DEPTH-1:0];
                                    depth_next = depth_reg + DW'(1);
                                end
                            end else if (is_close) begin
                                if (depth_reg != '0 && kinds_reg[0] == close_kind) begin
                                    kinds_next = pop_vec[STACK_DEPTH:1];
                                    depth_next = depth_reg - DW'(1);
                                end
                            end
                            if (item.cls != CLS_BLANK) begin
                                vis_pos_next   = written_reg;
                                vis_comma_next = (item.cls == CLS_COMMA);
                            end
                            written_next   = written_inc;
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                            out_next       = '0;
                            out_next.write_enable   = 1'b1;
                            out_next.write_position = written_reg;
                            out_next.write_byte     = item.data_byte;
                        end else if (is_open) begin
                            // opener seen but buffer already full
                            started_next = 1'b1;
                        end
                    end else begin
                        if (depth_reg != '0 && room) begin
                            state_next    = ST_CLOSE;
                            fix_pend_next = fix_now;
                            cpos_next     = fix_now ? vis_pos_reg : 16'd0;
                        end else begin
                            // no open level or no room for a closer: single status result
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            out_next       = '0;
                            out_next.fix_comma      = fix_now;
                            out_next.comma_position = fix_now ? vis_pos_reg : 16'd0;
                            out_next.success        = ok;
                            out_next.final_length   = written_reg;
                            started_next   = 1'b0;
                            written_next   = '0;
                            depth_next     = '0;
                            vis_pos_next   = '0;
                            vis_comma_next = 1'b0;
                        end
                    end
                end
            end
            ST_CLOSE: begin
                if (load_ok) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.write_enable   = 1'b1;
                    out_next.write_position = written_reg;
                    out_next.write_byte     = kinds_reg[0] ? CH_RBRACK : CH_RBRACE;
                    out_next.fix_comma      = fix_pend_reg;
                    out_next.comma_position = fix_pend_reg ? cpos_reg : 16'd0;
                    fix_pend_next  = 1'b0;
                    kinds_next     = pop_vec[STACK_DEPTH:1];
                    depth_next     = depth_reg - DW'(1);
                    written_next   = written_inc;
                    out_last_next  = 1'b0;
                    if (depth_reg == DW'(1) || written_inc >= cfg.limit) begin
                        out_last_next           = 1'b1;
                        out_next.success        = ok;
                        out_next.final_length   = written_inc;
                        state_next     = ST_RUN;
                        started_next   = 1'b0;
                        written_next   = '0;
                        depth_next     = '0;
                        vis_pos_next   = '0;
                        vis_comma_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            started_reg   <= 1'b0;
            written_reg   <= '0;
            depth_reg     <= '0;
            vis_pos_reg   <= '0;
            vis_comma_reg <= 1'b0;
            fix_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            written_reg   <= written_next;
            depth_reg     <= depth_next;
            vis_pos_reg   <= vis_pos_next;
            vis_comma_reg <= vis_comma_next;
            fix_pend_reg  <= fix_pend_next;
            out_valid_reg <= out_valid_next;
        end
        kinds_reg    <= kinds_next;
        cpos_reg     <= cpos_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* hdl/json_bracket_repair_stream.sv */
// Top level: JSON bracket repair stream with APB configuration.
// Path: a data byte passes the front item register, then the queue, then the back end's out reg,
// from which it is transferred.
// Throughput: one data byte per cycle; an end item with open levels and room left yields closers, one per cycle.
// Rate is set by the back end: one queued item or one closer per cycle, unless the output stalls.
// Reset (aresetn, synchronous, active low): empty pipeline and queue, no stream open,
// buffer_size back to 4096. The bracket stack contents are not reset.
module json_bracket_repair_stream #(
    parameter int STACK_DEPTH = 64,  // 1..64 open levels tracked
    parameter int QUEUE_DEPTH = 4    // front/back queue entries, power of two
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command (0 data, 1 end)
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [0] write_enable, [16:1] write_position,
                                   // [24:17] write_byte, [25] fix_comma,
                                   // [41:26] comma_position, [42] success,
                                   // [58:43] final_length, [63:59] zero
    output logic        m_tlast,   // last result of an end item
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jbr_pkg::*;

    logic [16:0] buffer_size_reg, buffer_size_next;
    cfg_t        cfg;
    logic        cfg_write;

    logic        f_valid, f_ready;
    item_t       f_item;
    logic        q_valid, q_ready;
    item_t       q_item;
    result_t     res;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_SIZE);
    assign prdata    = (paddr[2] == REG_BUFFER_SIZE) ? {15'd0, buffer_size_reg} : 32'd0;

    always_comb begin
        buffer_size_next = buffer_size_reg;
        if (cfg_write) begin
            buffer_size_next = pwdata[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_size_reg <= BUFFER_SIZE_RESET;
        end else begin
            buffer_size_reg <= buffer_size_next;
        end
    end

    // One place is kept for the terminator; sizes above 64 KiB clamp.
    always_comb begin
        cfg.size_nonzero = (buffer_size_reg != 17'd0);
        if (buffer_size_reg[16]) begin
            cfg.limit = 16'hFFFF;
        end else if (buffer_size_reg[15:0] == 16'd0) begin
            cfg.limit = 16'd0;
        end else begin
            cfg.limit = buffer_size_reg[15:0] - 16'd1;
        end
    end

    // ---------------- front: accept and classify ----------------
    jbr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // ---------------- queue between front and back ----------------
    jbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // ---------------- back: stack, writes, closers ----------------
    jbr_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (res),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {(64 - RESULT_W)'(0), res};

endmodule
